[rtl/core/ssp_pkg.sv]
// ============================================================================
// Soft-start PWM controller package
// Shared types and constants for the soft-start PWM controller.
// ============================================================================
package ssp_pkg;

    // Width of the free-running PWM counter.
    localparam int PWM_BITS = 8;
    // Width used to compare the counter against the 8-bit duty.
    localparam int CMP_W = (PWM_BITS > 8) ? PWM_BITS : 8;

    // Configuration register indexes.
    localparam logic [1:0] REG_LONG_PRESS   = 2'd0;
    localparam logic [1:0] REG_REPEAT       = 2'd1;
    localparam logic [1:0] REG_IDLE_TIMEOUT = 2'd2;

    // Reset values.
    localparam logic [7:0] LONG_PRESS_RST   = 8'd40;
    localparam logic [2:0] REPEAT_RST       = 3'd4;
    localparam logic [6:0] IDLE_TIMEOUT_RST = 7'd120;
    localparam logic [7:0] TARGET_RST       = 8'h80;
    localparam logic [6:0] IDLE_COUNT_RST   = 7'd120;

    // Saturation limits.
    localparam logic [6:0] IDLE_MAX = 7'd127;
    localparam logic [7:0] HOLD_MAX = 8'd255;
    localparam logic [1:0] WAKE_MAX = 2'd2;

    typedef struct packed {
        logic adjust_pressed;
        logic start_pressed;
        logic tick_slow;
        logic tick_ramp;
    } ssp_in_t;

    typedef struct packed {
        logic       pwm_out;
        logic       backlight_on;
        logic [7:0] set_point;
        logic [7:0] duty_now;
        logic       ramp_active;
    } ssp_out_t;

    typedef struct packed {
        logic [7:0] long_press_ticks;
        logic [2:0] repeat_ticks;
        logic [6:0] idle_timeout_ticks;
    } ssp_cfg_t;

endpackage

[rtl/core/ssp_cfg.sv]
// ============================================================================
// Soft-start PWM configuration registers
// Holds the long-press, repeat and idle-timeout settings.
// ============================================================================
module ssp_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    output ssp_pkg::ssp_cfg_t   cfg
);

    logic [7:0] long_press_reg;
    logic [2:0] repeat_reg;
    logic [6:0] idle_timeout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg   <= ssp_pkg::LONG_PRESS_RST;
            repeat_reg       <= ssp_pkg::REPEAT_RST;
            idle_timeout_reg <= ssp_pkg::IDLE_TIMEOUT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ssp_pkg::REG_LONG_PRESS:   long_press_reg   <= cfg_data;
                ssp_pkg::REG_REPEAT:       repeat_reg       <= cfg_data[2:0];
                ssp_pkg::REG_IDLE_TIMEOUT: idle_timeout_reg <= cfg_data[6:0];
                default:
                begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    assign cfg.long_press_ticks   = long_press_reg;
    assign cfg.repeat_ticks       = repeat_reg;
    assign cfg.idle_timeout_ticks = idle_timeout_reg;

endmodule

[rtl/core/ssp_core.sv]
// ============================================================================
// Soft-start PWM controller core
// Controller state and the per-tick update that yields one result beat.
// ============================================================================
module ssp_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  ssp_pkg::ssp_in_t    item,
    input  ssp_pkg::ssp_cfg_t   cfg,
    output ssp_pkg::ssp_out_t   result
);

    logic [ssp_pkg::PWM_BITS-1:0] pwm_count_reg, pwm_count_next;
    logic [7:0] duty_reg, duty_next;
    logic [7:0] target_reg, target_next;
    logic       ramping_reg, ramping_next;
    logic       adjust_held_reg, adjust_held_next;
    logic       start_held_reg, start_held_next;
    logic       fast_repeat_reg, fast_repeat_next;
    logic [7:0] hold_count_reg, hold_count_next;
    logic [2:0] repeat_count_reg, repeat_count_next;
    logic [6:0] idle_count_reg, idle_count_next;
    logic [1:0] wake_count_reg, wake_count_next;
    logic       light_reg, light_next;

    logic [ssp_pkg::CMP_W-1:0] count_ext;
    logic [ssp_pkg::CMP_W-1:0] duty_ext;

    always_comb
    begin
        pwm_count_next    = pwm_count_reg;
        duty_next         = duty_reg;
        target_next       = target_reg;
        ramping_next      = ramping_reg;
        adjust_held_next  = adjust_held_reg;
        start_held_next   = start_held_reg;
        fast_repeat_next  = fast_repeat_reg;
        hold_count_next   = hold_count_reg;
        repeat_count_next = repeat_count_reg;
        idle_count_next   = idle_count_reg;
        wake_count_next   = wake_count_reg;
        light_next        = light_reg;

        // Slow time base work comes first.
        if (item.tick_slow)
        begin
            if (idle_count_next < ssp_pkg::IDLE_MAX)
                idle_count_next = idle_count_next + 7'd1;
            if (idle_count_next > cfg.idle_timeout_ticks)
            begin
                light_next      = 1'b0;
                idle_count_next = cfg.idle_timeout_ticks;
                wake_count_next = 2'd0;
            end
            if (adjust_held_next && (hold_count_next < ssp_pkg::HOLD_MAX))
                hold_count_next = hold_count_next + 8'd1;
            if ((cfg.long_press_ticks != 8'd0) && (hold_count_next == cfg.long_press_ticks))
                fast_repeat_next = 1'b1;
            repeat_count_next = repeat_count_next + 3'd1;
            if (repeat_count_next == cfg.repeat_ticks)
            begin
                repeat_count_next = 3'd0;
                if (fast_repeat_next)
                    target_next = target_next + 8'd1;
            end
        end

        // The buttons are ignored while the ramp runs.
        if (ramping_next)
        begin
            if (item.tick_ramp)
            begin
                if (duty_next < target_next)
                    duty_next = duty_next + 8'd1;
                else
                    ramping_next = 1'b0;
            end
        end
        else
        begin
            if (item.adjust_pressed)
            begin
                adjust_held_next = 1'b1;
                light_next       = 1'b1;
                idle_count_next  = 7'd0;
            end
            else if (adjust_held_next)
            begin
                adjust_held_next = 1'b0;
                hold_count_next  = 8'd0;
                fast_repeat_next = 1'b0;
                if (wake_count_next < ssp_pkg::WAKE_MAX)
                    wake_count_next = wake_count_next + 2'd1;
                // The release that wakes the backlight does not step the set-point.
                if (wake_count_next >= ssp_pkg::WAKE_MAX)
                    target_next = target_next + 8'd1;
            end
            if (item.start_pressed)
            begin
                start_held_next = 1'b1;
            end
            else if (start_held_next)
            begin
                start_held_next = 1'b0;
                duty_next       = 8'd0;
                if (target_next != 8'd0)
                begin
                    duty_next    = 8'd1;
                    ramping_next = 1'b1;
                end
            end
        end

        pwm_count_next = pwm_count_reg + 1'b1;
    end

    assign count_ext = ssp_pkg::CMP_W'(pwm_count_reg);
    assign duty_ext  = ssp_pkg::CMP_W'(duty_next);

    assign result.pwm_out      = (duty_next != 8'd0) && (count_ext < duty_ext);
    assign result.backlight_on = light_next;
    assign result.set_point    = target_next;
    assign result.duty_now     = duty_next;
    assign result.ramp_active  = ramping_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_count_reg    <= '0;
            duty_reg         <= 8'd0;
            target_reg       <= ssp_pkg::TARGET_RST;
            ramping_reg      <= 1'b0;
            adjust_held_reg  <= 1'b0;
            start_held_reg   <= 1'b0;
            fast_repeat_reg  <= 1'b0;
            hold_count_reg   <= 8'd0;
            repeat_count_reg <= 3'd0;
            idle_count_reg   <= ssp_pkg::IDLE_COUNT_RST;
            wake_count_reg   <= 2'd0;
            light_reg        <= 1'b0;
        end
        else if (fire)
        begin
            pwm_count_reg    <= pwm_count_next;
            duty_reg         <= duty_next;
            target_reg       <= target_next;
            ramping_reg      <= ramping_next;
            adjust_held_reg  <= adjust_held_next;
            start_held_reg   <= start_held_next;
            fast_repeat_reg  <= fast_repeat_next;
            hold_count_reg   <= hold_count_next;
            repeat_count_reg <= repeat_count_next;
            idle_count_reg   <= idle_count_next;
            wake_count_reg   <= wake_count_next;
            light_reg        <= light_next;
        end
    end

endmodule

[rtl/core/soft_start_pwm_controller.sv]
// ============================================================================
// Soft-start PWM controller
// DC motor PWM drive with set-point adjust, soft-start ramp and backlight.
// ============================================================================
// Each item beat is one PWM clock tick carrying the adjust and start button
// levels and the slow (25 ms) and ramp (10 ms) strobes. Every item beat
// produces exactly one result beat with the PWM level, backlight enable,
// set-point, present duty and ramp flag, all taken after that tick's update.
// An item beat is captured in an input register; when the output stage can
// load, the core updates its state and the result lands in an output
// register, where it is held while the receiver stalls. Throughput is one
// beat per cycle while the receiver does not stall, set by the state update
// in the core.
// The input register and the output register form two stages, so an item
// beat is still taken while one finished result waits. When the receiver
// stalls with both stages full, item_stall rises until the result is taken.
// Configuration writes (cfg_valid with cfg_ready, always high) update the
// long-press, repeat and idle-timeout registers; write them only when idle.
// Reset clears both stages and returns the controller to its power-up state:
// set-point 128, duty zero, backlight off, registers at 40, 4 and 120.
// ============================================================================
module soft_start_pwm_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  ssp_pkg::ssp_in_t    item,
    output logic                result_valid,
    input  logic                result_stall,
    output ssp_pkg::ssp_out_t   result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data
);

    logic               in_vld_reg;
    ssp_pkg::ssp_in_t   in_item_reg;
    logic               out_vld_reg;
    ssp_pkg::ssp_out_t  out_data_reg;
    logic               advance;
    logic               fire;
    ssp_pkg::ssp_cfg_t  cfg;
    ssp_pkg::ssp_out_t  core_result;

    assign cfg_ready = 1'b1;

    // The output stage can load whenever it is empty or being emptied.
    assign advance    = !(out_vld_reg && result_stall);
    assign fire       = in_vld_reg && advance;
    assign item_stall = in_vld_reg && !advance;

    ssp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ssp_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (!item_stall)
                in_vld_reg <= item_valid;
            if (advance)
                out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
            in_item_reg <= item;
        if (fire)
            out_data_reg <= core_result;
    end

    assign result_valid = out_vld_reg;
    assign result       = out_data_reg;

    // The input stage only backs up behind a full, stalled output stage.
    a_stall_needs_full_out: assert property (
        @(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall)
    ) else $error("item_stall without a stalled result");

    // A running ramp never shows a zero duty.
    a_ramp_duty_nonzero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && result.ramp_active) |-> (result.duty_now != 8'd0)
    ) else $error("ramp active with zero duty");

    // The motor drive is never high with zero duty.
    a_pwm_needs_duty: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && result.pwm_out) |-> (result.duty_now != 8'd0)
    ) else $error("pwm high with zero duty");

    // A full input stage that is not blocked always yields a result next cycle.
    a_fire_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        fire |=> result_valid
    ) else $error("processed beat did not reach the output stage");

endmodule
